>>> src/plc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    // fixed field widths
    localparam int DATA_W      = 32;
    localparam int PIU_W       = 5;
    localparam int IDX_IN_W    = 4;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SUM_W       = DATA_W + 3;
    localparam int DIV_STEPS   = PROD_W;

    // default table depth
    localparam int MAX_POINTS_DEF = 16;

    // smallest usable point count
    localparam int MIN_POINTS = 2;

    // opcodes of an input transfer
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_SCAN,
        ST_RD_LO,
        ST_LD_LO,
        ST_LD_HI,
        ST_MAG,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN
    } plc_state_t;

    // table read address source
    typedef enum logic [2:0] {
        ADDR_FIRST,
        ADDR_LAST,
        ADDR_ONE,
        ADDR_SCAN_NEXT,
        ADDR_LO,
        ADDR_HI
    } plc_addr_sel_t;

    // segment low index source
    typedef enum logic [1:0] {
        LO_FIRST,
        LO_LAST,
        LO_SCAN
    } plc_lo_sel_t;

    // controller to datapath commands
    typedef struct packed {
        plc_addr_sel_t addr_sel;
        logic          mem_write;
        logic          raw_load;
        logic          scan_init;
        logic          scan_inc;
        logic          lo_load;
        plc_lo_sel_t   lo_sel;
        logic          ld_lo;
        logic          diff_load;
        logic          mag_load;
        logic          mul_load;
        logic          div_start;
        logic          out_load;
    } plc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic raw_le;
        logic raw_lt;
        logic scan_at_last;
        logic zero_span;
        logic div_done;
    } plc_sts_t;

endpackage

`default_nettype wire

>>> src/plc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module plc_div
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [plc_pkg::PROD_W-1:0]     dividend,
    input  wire logic [plc_pkg::DATA_W-1:0]     divisor,
    output logic      [plc_pkg::PROD_W-1:0]     quotient,
    output logic                                done
);

    localparam int CNT_W = $clog2(plc_pkg::DIV_STEPS + 1);

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [plc_pkg::DATA_W-1:0]    rem_reg;
    logic [plc_pkg::DATA_W-1:0]    rem_next;
    logic [plc_pkg::PROD_W-1:0]    quo_reg;
    logic [plc_pkg::PROD_W-1:0]    quo_next;
    logic [plc_pkg::DATA_W-1:0]    den_reg;
    logic [plc_pkg::DATA_W:0]      shifted;
    logic [plc_pkg::DATA_W+1:0]    trial;

    // one restoring step per cycle
    always_comb
    begin
        shifted    = {rem_reg, quo_reg[plc_pkg::PROD_W-1]};
        trial      = {1'b0, shifted} - {2'b00, den_reg};
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            count_next = CNT_W'(plc_pkg::DIV_STEPS);
            rem_next   = '0;
            quo_next   = dividend;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CNT_W'(1);
            if (!trial[plc_pkg::DATA_W+1])
            begin
                rem_next = trial[plc_pkg::DATA_W-1:0];
                quo_next = {quo_reg[plc_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[plc_pkg::DATA_W-1:0];
                quo_next = {quo_reg[plc_pkg::PROD_W-2:0], 1'b0};
            end
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // remainder, quotient and divisor
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = (count_reg == '0);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !done)
        else $error("divider not busy after start");

endmodule

`default_nettype wire

>>> src/plc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module plc_dpath
#(
    parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire plc_pkg::plc_cmd_t                  cmd,
    output plc_pkg::plc_sts_t                       sts,
    input  wire logic                               cfg_wr_en,
    input  wire logic [plc_pkg::PIU_W-1:0]          cfg_wr_data,
    input  wire logic [plc_pkg::IDX_IN_W-1:0]       point_index,
    input  wire logic signed [plc_pkg::DATA_W-1:0]  point_x,
    input  wire logic signed [plc_pkg::DATA_W-1:0]  point_y,
    input  wire logic signed [plc_pkg::DATA_W-1:0]  raw_reading,
    output logic signed [plc_pkg::DATA_W-1:0]       calibrated,
    output logic                                    saturated,
    output logic                                    zero_span
);

    localparam int DW    = plc_pkg::DATA_W;
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (CNT_W > plc_pkg::PIU_W) ? CNT_W : plc_pkg::PIU_W;
    localparam int SW    = plc_pkg::SUM_W;
    localparam logic [plc_pkg::PROD_W-1:0] Q_LIMIT = plc_pkg::PROD_W'(1) << (DW + 1);
    localparam logic signed [SW-1:0] SUM_MAX = SW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SUM_MIN = SW'(-(64'sd1 <<< (DW - 1)));

    // breakpoint table, x in the upper half
    logic [2*DW-1:0]            mem [MAX_POINTS];
    logic [2*DW-1:0]            rd_data_reg;
    logic [IDX_W-1:0]           rd_addr;

    logic [plc_pkg::PIU_W-1:0]  points_in_use_reg;
    logic [CMP_W-1:0]           count_clamped;
    logic [CMP_W-1:0]           piu_ext;
    logic [IDX_W-1:0]           last_idx;

    logic signed [DW-1:0]       raw_reg;
    logic signed [DW-1:0]       rd_x;
    logic signed [DW-1:0]       rd_y;
    logic [IDX_W-1:0]           scan_reg;
    logic [IDX_W-1:0]           lo_reg;
    logic [IDX_W-1:0]           lo_next;
    logic signed [DW-1:0]       x0_reg;
    logic signed [DW-1:0]       y0_reg;
    logic signed [DW:0]         dx_reg;
    logic signed [DW:0]         dy_reg;
    logic signed [DW:0]         dr_reg;
    logic [DW:0]                dx_abs;
    logic [DW:0]                dy_abs;
    logic [DW:0]                dr_abs;
    logic [DW-1:0]              mag_dx_reg;
    logic [DW-1:0]              mag_dy_reg;
    logic [DW-1:0]              mag_dr_reg;
    logic                       neg_reg;
    logic                       zero_reg;
    logic [plc_pkg::PROD_W-1:0] prod_reg;
    logic [plc_pkg::PROD_W-1:0] quo;
    logic                       div_done;
    logic signed [SW-1:0]       y0_ext;
    logic signed [SW-1:0]       q_ext;
    logic signed [SW-1:0]       sum;
    logic signed [DW-1:0]       res_val;
    logic                       res_sat;
    logic                       wr_in_range;
    logic signed [DW-1:0]       calibrated_reg;
    logic                       saturated_reg;
    logic                       zero_span_reg;

    // point count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_in_use_reg <= plc_pkg::PIU_W'(plc_pkg::MIN_POINTS);
        end
        else if (cfg_wr_en)
        begin
            points_in_use_reg <= cfg_wr_data;
        end
    end

    // clamp count into the usable range
    always_comb
    begin
        piu_ext = CMP_W'(points_in_use_reg);
        priority if (piu_ext < CMP_W'(plc_pkg::MIN_POINTS))
        begin
            count_clamped = CMP_W'(plc_pkg::MIN_POINTS);
        end
        else if (piu_ext > CMP_W'(MAX_POINTS))
        begin
            count_clamped = CMP_W'(MAX_POINTS);
        end
        else
        begin
            count_clamped = piu_ext;
        end
        last_idx = IDX_W'(count_clamped - CMP_W'(1));
    end

    // read address select
    always_comb
    begin
        unique case (cmd.addr_sel)
            plc_pkg::ADDR_FIRST:     rd_addr = '0;
            plc_pkg::ADDR_LAST:      rd_addr = last_idx;
            plc_pkg::ADDR_ONE:       rd_addr = IDX_W'(1);
            plc_pkg::ADDR_SCAN_NEXT: rd_addr = scan_reg + IDX_W'(1);
            plc_pkg::ADDR_LO:        rd_addr = lo_reg;
            plc_pkg::ADDR_HI:        rd_addr = lo_reg + IDX_W'(1);
            default:                 rd_addr = '0;
        endcase
    end

    assign wr_in_range = (32'(point_index) < MAX_POINTS);

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && wr_in_range)
        begin
            mem[IDX_W'(point_index)] <= {point_x, point_y};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_x = rd_data_reg[2*DW-1:DW];
    assign rd_y = rd_data_reg[DW-1:0];

    // segment low index select
    always_comb
    begin
        unique case (cmd.lo_sel)
            plc_pkg::LO_FIRST: lo_next = '0;
            plc_pkg::LO_LAST:  lo_next = last_idx - IDX_W'(1);
            plc_pkg::LO_SCAN:  lo_next = scan_reg - IDX_W'(1);
            default:           lo_next = '0;
        endcase
    end

    // magnitudes of the differences
    always_comb
    begin
        dx_abs = dx_reg[DW] ? ((DW + 1)'(0) - dx_reg) : dx_reg;
        dy_abs = dy_reg[DW] ? ((DW + 1)'(0) - dy_reg) : dy_reg;
        dr_abs = dr_reg[DW] ? ((DW + 1)'(0) - dr_reg) : dr_reg;
    end

    // search, operand and arithmetic registers
    always_ff @(posedge clk)
    begin
        if (cmd.raw_load)
        begin
            raw_reg <= raw_reading;
        end
        if (cmd.scan_init)
        begin
            scan_reg <= IDX_W'(1);
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + IDX_W'(1);
        end
        if (cmd.lo_load)
        begin
            lo_reg <= lo_next;
        end
        if (cmd.ld_lo)
        begin
            x0_reg <= rd_x;
            y0_reg <= rd_y;
        end
        if (cmd.diff_load)
        begin
            dx_reg <= {rd_x[DW-1], rd_x} - {x0_reg[DW-1], x0_reg};
            dy_reg <= {rd_y[DW-1], rd_y} - {y0_reg[DW-1], y0_reg};
            dr_reg <= {raw_reg[DW-1], raw_reg} - {x0_reg[DW-1], x0_reg};
        end
        if (cmd.mag_load)
        begin
            mag_dx_reg <= dx_abs[DW-1:0];
            mag_dy_reg <= dy_abs[DW-1:0];
            mag_dr_reg <= dr_abs[DW-1:0];
            neg_reg    <= dy_reg[DW] ^ dr_reg[DW] ^ dx_reg[DW];
            zero_reg   <= (dx_reg == '0);
        end
        if (cmd.mul_load)
        begin
            prod_reg <= mag_dy_reg * mag_dr_reg;
        end
    end

    plc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (mag_dx_reg),
        .quotient (quo),
        .done     (div_done)
    );

    // add quotient to y0 and clip
    always_comb
    begin
        y0_ext = SW'(y0_reg);
        q_ext  = signed'({1'b0, quo[SW-2:0]});
        sum    = neg_reg ? (y0_ext - q_ext) : (y0_ext + q_ext);
        priority if (quo > Q_LIMIT)
        begin
            res_sat = 1'b1;
            res_val = neg_reg ? DW'(SUM_MIN) : DW'(SUM_MAX);
        end
        else if (sum > SUM_MAX)
        begin
            res_sat = 1'b1;
            res_val = DW'(SUM_MAX);
        end
        else if (sum < SUM_MIN)
        begin
            res_sat = 1'b1;
            res_val = DW'(SUM_MIN);
        end
        else
        begin
            res_sat = 1'b0;
            res_val = sum[DW-1:0];
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (zero_reg)
            begin
                calibrated_reg <= '0;
                saturated_reg  <= 1'b0;
                zero_span_reg  <= 1'b1;
            end
            else
            begin
                calibrated_reg <= res_val;
                saturated_reg  <= res_sat;
                zero_span_reg  <= 1'b0;
            end
        end
    end

    assign calibrated = calibrated_reg;
    assign saturated  = saturated_reg;
    assign zero_span  = zero_span_reg;

    always_comb
    begin
        sts.raw_le       = (raw_reg <= rd_x);
        sts.raw_lt       = (raw_reg < rd_x);
        sts.scan_at_last = (scan_reg == last_idx);
        sts.zero_span    = zero_reg;
        sts.div_done     = div_done;
    end

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_inc |-> (scan_reg != last_idx))
        else $error("scan ran past the last point");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (mag_dx_reg != '0))
        else $error("divide started with zero span");

endmodule

`default_nettype wire

>>> src/plc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module plc_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               op,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire plc_pkg::plc_sts_t  sts,
    output plc_pkg::plc_cmd_t       cmd
);

    plc_pkg::plc_state_t state_reg;
    plc_pkg::plc_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != plc_pkg::ST_IDLE);

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.addr_sel  = plc_pkg::ADDR_FIRST;
        cmd.mem_write = 1'b0;
        cmd.raw_load  = 1'b0;
        cmd.scan_init = 1'b0;
        cmd.scan_inc  = 1'b0;
        cmd.lo_load   = 1'b0;
        cmd.lo_sel    = plc_pkg::LO_FIRST;
        cmd.ld_lo     = 1'b0;
        cmd.diff_load = 1'b0;
        cmd.mag_load  = 1'b0;
        cmd.mul_load  = 1'b0;
        cmd.div_start = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            plc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == plc_pkg::OP_EVAL)
                    begin
                        cmd.raw_load = 1'b1;
                        state_next   = plc_pkg::ST_CHK_FIRST;
                    end
                    else
                    begin
                        cmd.mem_write = 1'b1;
                    end
                end
            end
            plc_pkg::ST_CHK_FIRST:
            begin
                if (sts.raw_le)
                begin
                    cmd.lo_load = 1'b1;
                    cmd.lo_sel  = plc_pkg::LO_FIRST;
                    state_next  = plc_pkg::ST_RD_LO;
                end
                else
                begin
                    cmd.addr_sel = plc_pkg::ADDR_LAST;
                    state_next   = plc_pkg::ST_CHK_LAST;
                end
            end
            plc_pkg::ST_CHK_LAST:
            begin
                if (!sts.raw_lt)
                begin
                    cmd.lo_load = 1'b1;
                    cmd.lo_sel  = plc_pkg::LO_LAST;
                    state_next  = plc_pkg::ST_RD_LO;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    cmd.addr_sel  = plc_pkg::ADDR_ONE;
                    state_next    = plc_pkg::ST_SCAN;
                end
            end
            plc_pkg::ST_SCAN:
            begin
                if (sts.raw_lt || sts.scan_at_last)
                begin
                    cmd.lo_load = 1'b1;
                    cmd.lo_sel  = plc_pkg::LO_SCAN;
                    state_next  = plc_pkg::ST_RD_LO;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    cmd.addr_sel = plc_pkg::ADDR_SCAN_NEXT;
                end
            end
            plc_pkg::ST_RD_LO:
            begin
                cmd.addr_sel = plc_pkg::ADDR_LO;
                state_next   = plc_pkg::ST_LD_LO;
            end
            plc_pkg::ST_LD_LO:
            begin
                cmd.ld_lo    = 1'b1;
                cmd.addr_sel = plc_pkg::ADDR_HI;
                state_next   = plc_pkg::ST_LD_HI;
            end
            plc_pkg::ST_LD_HI:
            begin
                cmd.diff_load = 1'b1;
                state_next    = plc_pkg::ST_MAG;
            end
            plc_pkg::ST_MAG:
            begin
                cmd.mag_load = 1'b1;
                state_next   = plc_pkg::ST_MUL;
            end
            plc_pkg::ST_MUL:
            begin
                if (sts.zero_span)
                begin
                    state_next = plc_pkg::ST_FIN;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    state_next   = plc_pkg::ST_DIV_GO;
                end
            end
            plc_pkg::ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = plc_pkg::ST_DIV_WAIT;
            end
            plc_pkg::ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = plc_pkg::ST_FIN;
                end
            end
            plc_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = plc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plc_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == plc_pkg::OP_EVAL)
            |=> state_reg == plc_pkg::ST_CHK_FIRST)
        else $error("evaluate transfer did not start the search");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a stalled result");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (out_valid && state_reg == plc_pkg::ST_IDLE))
        else $error("result load did not raise valid");

endmodule

`default_nettype wire

>>> src/piecewise_linear_calibration_top.sv
// write transfer: taken while idle, table entry usable on the next cycle
// equal x span: the divider is skipped
// evaluates do not overlap: input stalled until the result is loaded; run time set by the 64-step serial divider
// plus the table search that reads one entry per cycle
// reset: control cleared, point count 2, breakpoint table undefined until written
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_calibration_top
#(
    parameter int MAX_POINTS = plc_pkg::MAX_POINTS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [plc_pkg::PIU_W-1:0]          cfg_wr_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               op,
    input  wire logic [plc_pkg::IDX_IN_W-1:0]       point_index,
    input  wire logic signed [plc_pkg::DATA_W-1:0]  point_x,
    input  wire logic signed [plc_pkg::DATA_W-1:0]  point_y,
    input  wire logic signed [plc_pkg::DATA_W-1:0]  raw_reading,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [plc_pkg::DATA_W-1:0]       calibrated,
    output logic                                    saturated,
    output logic                                    zero_span
);

    plc_pkg::plc_cmd_t cmd;
    plc_pkg::plc_sts_t sts;

    // sequencer
    plc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table, search compare and arithmetic
    plc_dpath
    #(
        .MAX_POINTS (MAX_POINTS)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .raw_reading (raw_reading),
        .calibrated  (calibrated),
        .saturated   (saturated),
        .zero_span   (zero_span)
    );

endmodule

`default_nettype wire
